@@ design/edf_pkg.sv @@
// Shared types and constants of the non-preemptive EDF dispatcher.
// Used by edf_rem_unit and nonpreemptive_edf_dispatcher_unit; no dependencies.
`timescale 1ns / 1ps

package edf_pkg;

  // Field widths fixed by the register and stream layout
  localparam int unsigned PERIOD_W    = 16;
  localparam int unsigned COST_W      = 16;
  localparam int unsigned HP_W        = 16;
  localparam int unsigned COUNT_W     = 3;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 32;
  localparam int unsigned OUT_IDX_W   = 2;
  localparam int unsigned OUT_NUM_W   = 16;
  localparam int unsigned OUT_TIME_W  = 16;
  localparam int unsigned S_DATA_W    = 8;
  localparam int unsigned M_DATA_W    = 40;
  localparam int unsigned PARAM_REGS  = 4;

  // Reset value of each task register: period 1, cost 1
  localparam logic [CFG_DATA_W-1:0] PARAM_RESET = 32'h0001_0001;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TASK_COUNT   = 3'd0,
    REG_HYPERPERIOD  = 3'd1,
    REG_TASK0_PARAMS = 3'd2,
    REG_TASK1_PARAMS = 3'd3,
    REG_TASK2_PARAMS = 3'd4,
    REG_TASK3_PARAMS = 3'd5
  } cfg_reg_e;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REL_CHECK,
    ST_REL_WAIT,
    ST_SELECT,
    ST_DONE
  } seq_state_e;

  // Control strobes decoded from the sequencer state
  typedef struct packed {
    logic s_ready;
    logic rem_start;
    logic out_load;
  } seq_ctrl_t;

endpackage

@@ design/edf_rem_unit.sv @@
// Shared bit-serial remainder unit: dividend mod divisor, one bit per cycle.
// Depends on edf_pkg for the divisor width.
`timescale 1ns / 1ps

module edf_rem_unit #(
  parameter int unsigned DIV_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [DIV_BITS-1:0]           dividend_i,
  input  logic [edf_pkg::PERIOD_W-1:0]  divisor_i,
  output logic                          done_o,
  output logic                          rem_zero_o
);

  localparam int unsigned KW = (DIV_BITS > 1) ? $clog2(DIV_BITS) : 1;
  localparam int unsigned RW = edf_pkg::PERIOD_W;

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [KW-1:0]     step_q, step_d;
  logic [DIV_BITS-1:0] num_q, num_d;
  logic [RW-1:0]     div_q, div_d;
  logic [RW-1:0]     rem_q, rem_d;
  logic [RW:0]       trial;
  logic [RW:0]       diff;
  logic              last_step;

  // One restoring step: shift in the next dividend bit, subtract if it fits
  always_comb begin
    trial     = {rem_q, num_q[DIV_BITS-1]};
    diff      = trial - {1'b0, div_q};
    last_step = (step_q == KW'(DIV_BITS - 1));
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    num_d  = num_q;
    div_d  = div_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = '0;
      num_d  = dividend_i;
      div_d  = divisor_i;
      rem_d  = '0;
    end else if (busy_q) begin
      rem_d  = (trial >= {1'b0, div_q}) ? diff[RW-1:0] : trial[RW-1:0];
      num_d  = num_q << 1;
      step_d = step_q + KW'(1);
      if (last_step) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  // Hold operands and partial remainder
  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    div_q <= div_d;
    rem_q <= rem_d;
  end

  assign done_o     = done_q;
  assign rem_zero_o = (rem_q == '0);

endmodule

@@ design/nonpreemptive_edf_dispatcher_unit.sv @@
// Top level of the non-preemptive EDF dispatcher: configuration registers,
// tick sequencer, task state and output register. Uses edf_pkg and edf_rem_unit.
`timescale 1ns / 1ps

// Usage:
// Each beat on the s_axis channel is one scheduler tick; tdata[0] is restart,
// which returns time, the running job and the dispatch count to zero and drops
// all pending jobs before the tick is processed. Each tick gives exactly one
// beat on m_axis: tuser says a job started, tdata carries the task index, the
// dispatch number and the tick time, tlast marks the last tick of the
// hyperperiod. Registers are to be written over the cfg channel (always ready)
// only while no tick is in flight; the block does not enforce this.
// Sequence: a tick is accepted in the idle state, then each task in use is
// visited once for release: a task with a nonzero period runs the shared
// remainder unit, a zero period only advances the loop. When the release loop
// closes and no job runs, the earliest-deadline pick visits each task in use;
// the final state then loads the output.
// The result sits in an output register, so the next tick is taken while it
// waits; a stalled receiver holds the block in its final state until the
// register frees. Reset clears all control state and restores register values.

module nonpreemptive_edf_dispatcher_unit #(
  parameter int unsigned NUM_TASKS = 4,
  parameter int unsigned TIME_BITS = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Tick input, tdata: restart (bit 0), zeros above
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [edf_pkg::S_DATA_W-1:0]     s_axis_tdata,
  // Result, tdata: task_index [1:0], dispatch_number [17:2], tick_time [33:18]
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [edf_pkg::M_DATA_W-1:0]     m_axis_tdata,
  // tuser: dispatched
  output logic                             m_axis_tuser,
  // tlast: period_end
  output logic                             m_axis_tlast,
  // Configuration writes
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [edf_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [edf_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  localparam int unsigned WB   = (TIME_BITS > edf_pkg::PERIOD_W) ? TIME_BITS
                                                                 : edf_pkg::PERIOD_W;
  localparam int unsigned CW   = WB + 1;
  localparam int unsigned DW   = TIME_BITS + 1;
  localparam int unsigned IW   = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
  localparam int unsigned CNTW = $clog2(NUM_TASKS + 1);
  localparam int unsigned PADW = edf_pkg::M_DATA_W - edf_pkg::OUT_IDX_W
                                 - edf_pkg::OUT_NUM_W - edf_pkg::OUT_TIME_W;

  // Configuration state
  logic [edf_pkg::COUNT_W-1:0]    task_count_q;
  logic [edf_pkg::HP_W-1:0]       hyperperiod_q;
  logic [edf_pkg::CFG_DATA_W-1:0] params_q [NUM_TASKS];
  logic [edf_pkg::OUT_IDX_W-1:0]  wr_task;
  logic                           cfg_we;

  // Scheduler state
  edf_pkg::seq_state_e            state_q, state_d;
  edf_pkg::seq_ctrl_t             ctrl;
  logic [CNTW-1:0]                cnt_q;
  logic [TIME_BITS-1:0]           time_q;
  logic [edf_pkg::COST_W-1:0]     busy_q;
  logic [edf_pkg::OUT_NUM_W-1:0]  dcount_q;
  logic [NUM_TASKS-1:0]           pending_q;
  logic [DW-1:0]                  deadline_q [NUM_TASKS];
  logic                           found_q;
  logic [IW-1:0]                  best_idx_q;
  logic [DW-1:0]                  best_dl_q;
  logic [edf_pkg::COST_W-1:0]     best_cost_q;

  // Output register
  logic                           m_valid_q;
  logic [edf_pkg::M_DATA_W-1:0]   m_data_q;
  logic                           m_user_q;
  logic                           m_last_q;

  // Derived values
  logic                           s_accept;
  logic                           rem_done, rem_zero;
  logic [CNTW-1:0]                n_tasks;
  logic                           cnt_lt_n;
  logic [IW-1:0]                  cur;
  logic [edf_pkg::PERIOD_W-1:0]   cur_period;
  logic [edf_pkg::COST_W-1:0]     cur_cost;
  logic [DW-1:0]                  cur_dl;
  logic                           better;
  logic                           dispatching;
  logic [CW-1:0]                  now_ext;
  logic [CW-1:0]                  now_inc;
  logic [CW-1:0]                  hp_eff;
  logic                           period_end;
  logic [edf_pkg::COST_W-1:0]     best_cost_m1;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;
  assign wr_task     = edf_pkg::OUT_IDX_W'(cfg_index_i - edf_pkg::REG_TASK0_PARAMS);

  // Task under the loop counter and per-step decisions
  always_comb begin
    n_tasks     = ({29'd0, task_count_q} > 32'(NUM_TASKS)) ? CNTW'(NUM_TASKS)
                                                          : CNTW'(task_count_q);
    cnt_lt_n    = (cnt_q < n_tasks);
    cur         = cnt_q[IW-1:0];
    cur_period  = params_q[cur][31:16];
    cur_cost    = (params_q[cur][15:0] == '0) ? edf_pkg::COST_W'(1) : params_q[cur][15:0];
    cur_dl      = deadline_q[cur];
    better      = !found_q || (cur_dl < best_dl_q) ||
                  ((cur_dl == best_dl_q) && (cur_cost > best_cost_q));
    dispatching = (busy_q == '0) && found_q;
    now_ext     = CW'(time_q);
    now_inc     = now_ext + CW'(1);
    hp_eff      = (hyperperiod_q == '0) ? CW'(1) : CW'(hyperperiod_q);
    period_end  = (now_inc >= hp_eff);
    best_cost_m1 = best_cost_q - edf_pkg::COST_W'(1);
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      edf_pkg::ST_IDLE: begin
        if (s_accept) state_d = edf_pkg::ST_REL_CHECK;
      end
      edf_pkg::ST_REL_CHECK: begin
        if (!cnt_lt_n) begin
          state_d = (busy_q != '0) ? edf_pkg::ST_DONE : edf_pkg::ST_SELECT;
        end else if (cur_period != '0) begin
          state_d = edf_pkg::ST_REL_WAIT;
        end
      end
      edf_pkg::ST_REL_WAIT: begin
        if (rem_done) state_d = edf_pkg::ST_REL_CHECK;
      end
      edf_pkg::ST_SELECT: begin
        if (!cnt_lt_n) state_d = edf_pkg::ST_DONE;
      end
      edf_pkg::ST_DONE: begin
        if (!m_valid_q || m_axis_tready) state_d = edf_pkg::ST_IDLE;
      end
      default: state_d = edf_pkg::ST_IDLE;
    endcase
  end

  // Control strobes
  always_comb begin
    ctrl = '0;
    case (state_q)
      edf_pkg::ST_IDLE:      ctrl.s_ready   = 1'b1;
      edf_pkg::ST_REL_CHECK: ctrl.rem_start = cnt_lt_n && (cur_period != '0);
      edf_pkg::ST_DONE:      ctrl.out_load  = !m_valid_q || m_axis_tready;
      default:               ctrl = '0;
    endcase
  end

  assign s_axis_tready = ctrl.s_ready;
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  edf_rem_unit #(
    .DIV_BITS (WB)
  ) u_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (ctrl.rem_start),
    .dividend_i (WB'(time_q)),
    .divisor_i  (cur_period),
    .done_o     (rem_done),
    .rem_zero_o (rem_zero)
  );

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      task_count_q  <= edf_pkg::COUNT_W'(1);
      hyperperiod_q <= edf_pkg::HP_W'(1);
      for (int t = 0; t < NUM_TASKS; t++) begin
        params_q[t] <= edf_pkg::PARAM_RESET;
      end
    end else if (cfg_we) begin
      case (cfg_index_i)
        edf_pkg::REG_TASK_COUNT:  task_count_q  <= cfg_data_i[edf_pkg::COUNT_W-1:0];
        edf_pkg::REG_HYPERPERIOD: hyperperiod_q <= cfg_data_i[edf_pkg::HP_W-1:0];
        edf_pkg::REG_TASK0_PARAMS, edf_pkg::REG_TASK1_PARAMS,
        edf_pkg::REG_TASK2_PARAMS, edf_pkg::REG_TASK3_PARAMS: begin
          for (int t = 0; t < NUM_TASKS; t++) begin
            if (32'(t) == 32'(wr_task)) params_q[t] <= cfg_data_i;
          end
        end
        default: ;
      endcase
    end
  end

  // Sequencer and scheduler control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= edf_pkg::ST_IDLE;
      cnt_q     <= '0;
      time_q    <= '0;
      busy_q    <= '0;
      dcount_q  <= '0;
      pending_q <= '0;
      found_q   <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;

      // Take a tick: restart drops everything before release
      if (s_accept) begin
        cnt_q   <= '0;
        found_q <= 1'b0;
        if (s_axis_tdata[0]) begin
          time_q    <= '0;
          busy_q    <= '0;
          dcount_q  <= '0;
          pending_q <= '0;
        end
      end

      // Advance the release loop
      if (state_q == edf_pkg::ST_REL_CHECK) begin
        if (!cnt_lt_n) begin
          cnt_q <= '0;
        end else if (cur_period == '0) begin
          cnt_q <= cnt_q + CNTW'(1);
        end
      end
      if (state_q == edf_pkg::ST_REL_WAIT && rem_done) begin
        if (rem_zero) pending_q[cur] <= 1'b1;
        cnt_q <= cnt_q + CNTW'(1);
      end

      // Advance the earliest-deadline search
      if (state_q == edf_pkg::ST_SELECT && cnt_lt_n) begin
        cnt_q <= cnt_q + CNTW'(1);
        if (pending_q[cur] && better) found_q <= 1'b1;
      end

      // Close the tick: run down or start a job, advance time or wrap it to zero
      if (ctrl.out_load) begin
        if (busy_q != '0) begin
          busy_q <= busy_q - edf_pkg::COST_W'(1);
        end else if (found_q) begin
          pending_q[best_idx_q] <= 1'b0;
          busy_q   <= best_cost_m1;
        end
        if (period_end) begin
          time_q   <= '0;
          dcount_q <= '0;
        end else begin
          time_q <= now_inc[TIME_BITS-1:0];
          if (dispatching) dcount_q <= dcount_q + edf_pkg::OUT_NUM_W'(1);
        end
      end

      // Output valid
      if (ctrl.out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // Payload: deadlines, best candidate, output beat
  always_ff @(posedge clk_i) begin
    if (state_q == edf_pkg::ST_REL_WAIT && rem_done && rem_zero) begin
      deadline_q[cur] <= DW'(now_ext + CW'(cur_period));
    end
    if (state_q == edf_pkg::ST_SELECT && cnt_lt_n && pending_q[cur] && better) begin
      best_idx_q  <= cur;
      best_dl_q   <= cur_dl;
      best_cost_q <= cur_cost;
    end
    if (ctrl.out_load) begin
      m_data_q <= {{PADW{1'b0}},
                   edf_pkg::OUT_TIME_W'(time_q),
                   dispatching ? dcount_q : edf_pkg::OUT_NUM_W'(0),
                   dispatching ? edf_pkg::OUT_IDX_W'(best_idx_q)
                               : edf_pkg::OUT_IDX_W'(0)};
      m_user_q <= dispatching;
      m_last_q <= period_end;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;
  assign m_axis_tlast  = m_last_q;

  // The output register is never overwritten while a beat waits
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.out_load |-> (!m_valid_q || m_axis_tready))
    else $error("output beat overwritten while stalled");

  // A job still running blocks any new dispatch on this tick
  a_busy_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl.out_load && (busy_q != '0)) |=> !m_axis_tuser)
    else $error("dispatch while a job is running");

  // The remainder unit only finishes while the sequencer waits on it
  a_rem_done_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rem_done |-> (state_q == edf_pkg::ST_REL_WAIT))
    else $error("remainder result outside release wait");

endmodule

@@ bench/tb_top.sv @@
// Self-checking bench for nonpreemptive_edf_dispatcher_unit: streams ticks,
// predicts every dispatch beat in-bench and compares each result field.
// Depends on edf_pkg and the dispatcher RTL only.
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned TASKS          = 4;
  localparam int unsigned TASK_IDX_W     = $clog2(TASKS);
  localparam int unsigned TIME_W         = 16;
  localparam int unsigned IDLE_MAX       = 12;
  localparam int unsigned TICKS_TOTAL    = 950;
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned SETTLE_CYCLES  = 200;

  // Register slots the block does not decode
  localparam logic [edf_pkg::CFG_IDX_W-1:0] CFG_IDX_SPARE_LO = 3'd6;
  localparam logic [edf_pkg::CFG_IDX_W-1:0] CFG_IDX_SPARE_HI = 3'd7;

  typedef enum logic [1:0] {
    STIM_TICK,
    STIM_CFG,
    STIM_DRAIN
  } stim_kind_e;

  typedef struct {
    stim_kind_e                      kind;
    logic                            restart;
    logic [edf_pkg::CFG_IDX_W-1:0]   reg_index;
    logic [edf_pkg::CFG_DATA_W-1:0]  reg_value;
    int unsigned                     gap;
    logic                            quiet;
  } plan_item_t;

  typedef struct packed {
    logic                           dispatched;
    logic [edf_pkg::OUT_IDX_W-1:0]  task_idx;
    logic [edf_pkg::OUT_NUM_W-1:0]  disp_num;
    logic [edf_pkg::OUT_TIME_W-1:0] tick_time;
    logic                           period_end;
  } dispatch_result_t;

  // DUT ports, all driven from time zero
  logic                           clk_i          = 1'b0;
  logic                           rst_ni         = 1'b0;
  logic                           s_axis_tvalid  = 1'b0;
  logic                           s_axis_tready;
  logic [edf_pkg::S_DATA_W-1:0]   s_axis_tdata   = '0;
  logic                           m_axis_tvalid;
  logic                           m_axis_tready  = 1'b0;
  logic [edf_pkg::M_DATA_W-1:0]   m_axis_tdata;
  logic                           m_axis_tuser;
  logic                           m_axis_tlast;
  logic                           cfg_valid_i    = 1'b0;
  logic                           cfg_ready_o;
  logic [edf_pkg::CFG_IDX_W-1:0]  cfg_index_i    = '0;
  logic [edf_pkg::CFG_DATA_W-1:0] cfg_data_i     = '0;

  // Scheduler shadow state
  logic [edf_pkg::COUNT_W-1:0]    sched_count;
  logic [edf_pkg::HP_W-1:0]       sched_hp;
  logic [edf_pkg::CFG_DATA_W-1:0] task_word [TASKS];
  logic [TIME_W-1:0]              sched_time;
  logic [TIME_W:0]                job_dl [TASKS];
  logic [TASKS-1:0]               job_pending;
  logic [TIME_W-1:0]              busy_left;
  logic [edf_pkg::OUT_NUM_W-1:0]  disp_cnt;

  plan_item_t       schedule_plan_q [$];
  dispatch_result_t expected_dispatch_q [$];
  plan_item_t       plan_item;
  logic             plan_active  = 1'b0;
  logic             rx_quiet     = 1'b0;
  int unsigned      rx_stall     = 0;
  int unsigned      ticks_planned = 0;
  int unsigned      fault_count  = 0;
  int unsigned      idle_cycles  = 0;
  logic             tick_fired   = 1'b0;
  logic             cfg_fired    = 1'b0;
  logic             result_fired = 1'b0;

  nonpreemptive_edf_dispatcher_unit #(
    .NUM_TASKS(TASKS),
    .TIME_BITS(TIME_W)
  ) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin : clock_gen
    forever #1 clk_i = ~clk_i;
  end

  task automatic report_fault(input string msg);
    $display("[%0t] ERROR %s", $realtime, msg);
    fault_count++;
  endtask

  // Zero cost runs and ties as one tick
  function automatic logic [TIME_W:0] eff_cost(input logic [edf_pkg::CFG_DATA_W-1:0] word);
    return (word[edf_pkg::COST_W-1:0] == '0) ? 17'd1 : {1'b0, word[edf_pkg::COST_W-1:0]};
  endfunction

  // Advance the shadow schedule by one tick and return the beat it produces
  function automatic dispatch_result_t advance_schedule(input logic restart);
    dispatch_result_t res;
    logic [TIME_W:0]  hp;
    logic [TIME_W:0]  now17;
    logic [TIME_W:0]  p17;
    int unsigned      n;
    int unsigned      i;
    int unsigned      best;
    logic             found;
    res   = '0;
    found = 1'b0;
    best  = 0;
    hp    = (sched_hp == '0) ? 17'd1 : {1'b0, sched_hp};
    if (restart) begin
      sched_time  = '0;
      busy_left   = '0;
      disp_cnt    = '0;
      job_pending = '0;
    end
    now17 = {1'b0, sched_time};
    n     = (sched_count > TASKS) ? TASKS : sched_count;

    // release jobs whose period divides the current time
    for (i = 0; i < n; i++) begin
      p17 = {1'b0, task_word[i][edf_pkg::CFG_DATA_W-1:edf_pkg::COST_W]};
      if (p17 != '0 && (now17 % p17) == '0) begin
        job_dl[i]      = now17 + p17;
        job_pending[i] = 1'b1;
      end
    end

    // pick earliest deadline, then larger cost, then lower index
    if (busy_left != '0) begin
      busy_left = busy_left - 1'b1;
    end else begin
      for (i = 0; i < n; i++) begin
        if (job_pending[i]) begin
          if (!found || job_dl[i] < job_dl[best] ||
              (job_dl[i] == job_dl[best] &&
               eff_cost(task_word[i]) > eff_cost(task_word[best]))) begin
            best  = i;
            found = 1'b1;
          end
        end
      end
      if (found) begin
        job_pending[best] = 1'b0;
        busy_left         = TIME_W'(eff_cost(task_word[best]) - 1'b1);
        res.dispatched    = 1'b1;
        res.task_idx      = edf_pkg::OUT_IDX_W'(best);
        res.disp_num      = disp_cnt;
        disp_cnt          = disp_cnt + 1'b1;
      end
    end

    res.tick_time  = sched_time;
    res.period_end = (now17 + 17'd1 >= hp);
    if (res.period_end) begin
      sched_time = '0;
      disp_cnt   = '0;
    end else begin
      sched_time = sched_time + 1'b1;
    end
    return res;
  endfunction

  function automatic void queue_tick(input logic restart, input logic quiet);
    plan_item_t it;
    it.kind      = STIM_TICK;
    it.restart   = restart;
    it.reg_index = '0;
    it.reg_value = '0;
    it.gap       = quiet ? 0 : $urandom_range(0, IDLE_MAX);
    it.quiet     = quiet;
    schedule_plan_q.push_back(it);
    ticks_planned++;
  endfunction

  function automatic void queue_cfg(input logic [edf_pkg::CFG_IDX_W-1:0] reg_index,
                                    input logic [edf_pkg::CFG_DATA_W-1:0] reg_value);
    plan_item_t it;
    it.kind      = STIM_CFG;
    it.restart   = 1'b0;
    it.reg_index = reg_index;
    it.reg_value = reg_value;
    it.gap       = 0;
    it.quiet     = 1'b0;
    schedule_plan_q.push_back(it);
  endfunction

  function automatic void queue_drain();
    plan_item_t it;
    it.kind      = STIM_DRAIN;
    it.restart   = 1'b0;
    it.reg_index = '0;
    it.reg_value = '0;
    it.gap       = 0;
    it.quiet     = 1'b0;
    schedule_plan_q.push_back(it);
  endfunction

  // Drive tick and config beats; config waits until no result is owed
  always @(negedge clk_i) begin : drive_stimulus
    logic hold_tick;
    logic hold_cfg;
    hold_tick = s_axis_tvalid && !tick_fired;
    hold_cfg  = cfg_valid_i && !cfg_fired;
    if (rst_ni && !hold_tick && !hold_cfg) begin
      if (!plan_active && schedule_plan_q.size() != 0) begin
        plan_item   = schedule_plan_q.pop_front();
        plan_active = 1'b1;
        rx_quiet    = plan_item.quiet;
      end
      if (plan_active) begin
        if (plan_item.gap != 0) begin
          plan_item.gap--;
        end else begin
          case (plan_item.kind)
            STIM_TICK: begin
              hold_tick    = 1'b1;
              s_axis_tdata <= {{(edf_pkg::S_DATA_W-1){1'b0}}, plan_item.restart};
              plan_active  = 1'b0;
            end
            STIM_CFG: begin
              if (expected_dispatch_q.size() == 0) begin
                hold_cfg    = 1'b1;
                cfg_index_i <= plan_item.reg_index;
                cfg_data_i  <= plan_item.reg_value;
                plan_active = 1'b0;
              end
            end
            default: begin
              if (expected_dispatch_q.size() == 0) begin
                plan_active = 1'b0;
              end
            end
          endcase
        end
      end
    end
    s_axis_tvalid <= hold_tick;
    cfg_valid_i   <= hold_cfg;
  end

  // Stall the result side for a drawn number of valid cycles per beat
  always @(negedge clk_i) begin : drive_ready
    if (rst_ni) begin
      if (result_fired) begin
        rx_stall = rx_quiet ? 0 : $urandom_range(0, IDLE_MAX);
      end
      if (rx_stall != 0) begin
        m_axis_tready <= 1'b0;
        if (m_axis_tvalid) begin
          rx_stall--;
        end
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Sample handshakes, update the shadow model and check result beats
  always @(posedge clk_i) begin : watch_ports
    dispatch_result_t want;
    if (rst_ni) begin
      tick_fired   <= s_axis_tvalid && s_axis_tready;
      cfg_fired    <= cfg_valid_i && cfg_ready_o;
      result_fired <= m_axis_tvalid && m_axis_tready;

      // check the result first: it never belongs to a tick taken this edge
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_dispatch_q.size() == 0) begin
          report_fault("result beat with no tick outstanding");
        end else begin
          want = expected_dispatch_q.pop_front();
          if (m_axis_tuser !== want.dispatched) begin
            report_fault($sformatf("t=%0d dispatched got %0b want %0b",
                                   want.tick_time, m_axis_tuser, want.dispatched));
          end
          if (m_axis_tdata[1:0] !== want.task_idx) begin
            report_fault($sformatf("t=%0d task_index got %0d want %0d",
                                   want.tick_time, m_axis_tdata[1:0], want.task_idx));
          end
          if (m_axis_tdata[17:2] !== want.disp_num) begin
            report_fault($sformatf("t=%0d dispatch_number got %0d want %0d",
                                   want.tick_time, m_axis_tdata[17:2], want.disp_num));
          end
          if (m_axis_tdata[33:18] !== want.tick_time) begin
            report_fault($sformatf("tick_time got %0d want %0d",
                                   m_axis_tdata[33:18], want.tick_time));
          end
          if (m_axis_tlast !== want.period_end) begin
            report_fault($sformatf("t=%0d period_end got %0b want %0b",
                                   want.tick_time, m_axis_tlast, want.period_end));
          end
        end
      end

      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          edf_pkg::REG_TASK_COUNT:   sched_count = cfg_data_i[edf_pkg::COUNT_W-1:0];
          edf_pkg::REG_HYPERPERIOD:  sched_hp    = cfg_data_i[edf_pkg::HP_W-1:0];
          edf_pkg::REG_TASK0_PARAMS,
          edf_pkg::REG_TASK1_PARAMS,
          edf_pkg::REG_TASK2_PARAMS,
          edf_pkg::REG_TASK3_PARAMS: begin
            task_word[TASK_IDX_W'(cfg_index_i - edf_pkg::REG_TASK0_PARAMS)] = cfg_data_i;
          end
          default: ;
        endcase
      end

      if (s_axis_tvalid && s_axis_tready) begin
        expected_dispatch_q.push_back(advance_schedule(s_axis_tdata[0]));
      end

      // watchdog on cycles with no beat on any channel
      if ((s_axis_tvalid && s_axis_tready) || (cfg_valid_i && cfg_ready_o) ||
          (m_axis_tvalid && m_axis_tready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("FAIL nonpreemptive_edf_dispatcher_unit");
        $finish;
      end
    end
  end

  initial begin : run_test
    int unsigned     t;
    int unsigned     k;
    int unsigned     hyper;
    int unsigned     lane_count;
    int unsigned     nticks;
    int unsigned     drain_at;
    logic [15:0]     period;
    logic [15:0]     cost;
    logic            phase_quiet;
    logic [edf_pkg::CFG_DATA_W-1:0] pad;

    // shadow state after reset
    sched_count = 3'd1;
    sched_hp    = 16'd1;
    sched_time  = '0;
    busy_left   = '0;
    disp_cnt    = '0;
    job_pending = '0;
    for (t = 0; t < TASKS; t++) begin
      task_word[t] = edf_pkg::PARAM_RESET;
      job_dl[t]    = '0;
    end

    // reset values: one task of period 1, hyperperiod 1, so every tick ends the hyperperiod
    queue_tick(1'b0, 1'b0);
    queue_tick(1'b0, 1'b0);
    queue_tick(1'b0, 1'b1);

    // full task set: deadline tie broken by cost, zero period, zero cost
    queue_cfg(edf_pkg::REG_TASK_COUNT,   32'd4);
    queue_cfg(edf_pkg::REG_HYPERPERIOD,  32'd12);
    queue_cfg(edf_pkg::REG_TASK0_PARAMS, {16'd4, 16'd1});
    queue_cfg(edf_pkg::REG_TASK1_PARAMS, {16'd4, 16'd2});
    queue_cfg(edf_pkg::REG_TASK2_PARAMS, {16'd0, 16'd3});
    queue_cfg(edf_pkg::REG_TASK3_PARAMS, {16'd6, 16'd0});
    for (k = 0; k < 9; k++) begin
      queue_tick(1'b0, k[0]);
    end
    queue_tick(1'b1, 1'b0);

    // hold the sender until everything has drained
    queue_drain();

    // no task in use
    queue_cfg(edf_pkg::REG_TASK_COUNT, 32'd0);
    queue_tick(1'b0, 1'b0);
    queue_tick(1'b0, 1'b0);

    // count saturates, zero hyperperiod, spare register slots
    queue_cfg(edf_pkg::REG_TASK_COUNT,   32'hFFFF_FFFF);
    queue_cfg(edf_pkg::REG_HYPERPERIOD,  32'h0000_0000);
    queue_cfg(CFG_IDX_SPARE_LO, 32'hFFFF_FFFF);
    queue_cfg(CFG_IDX_SPARE_HI, 32'hFFFF_FFFF);
    queue_tick(1'b0, 1'b0);
    queue_tick(1'b0, 1'b0);

    // longest period and cost, then hyperperiod lowered below current time
    queue_cfg(edf_pkg::REG_TASK_COUNT,   32'd1);
    queue_cfg(edf_pkg::REG_HYPERPERIOD,  32'hFFFF_FFFF);
    queue_cfg(edf_pkg::REG_TASK0_PARAMS, 32'hFFFF_FFFF);
    for (k = 0; k < 4; k++) begin
      queue_tick(1'b0, 1'b0);
    end
    queue_cfg(edf_pkg::REG_HYPERPERIOD, 32'd2);
    queue_tick(1'b0, 1'b0);
    queue_tick(1'b0, 1'b0);
    queue_cfg(edf_pkg::REG_TASK0_PARAMS, 32'd0);
    queue_tick(1'b1, 1'b0);

    // random task sets, mostly with periods that divide the hyperperiod
    while (ticks_planned < TICKS_TOTAL) begin
      phase_quiet = ($urandom_range(0, 3) == 0);
      hyper       = ($urandom_range(0, 11) == 0) ? $urandom_range(0, 65535)
                                                 : $urandom_range(1, 60);
      lane_count  = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 7)
                                                : $urandom_range(1, 4);
      pad = ($urandom_range(0, 3) == 0) ? $urandom : '0;
      if ($urandom_range(0, 3) != 0) begin
        queue_cfg(edf_pkg::REG_TASK_COUNT, (pad & 32'hFFFF_FFF8) | lane_count);
      end
      if ($urandom_range(0, 3) != 0) begin
        queue_cfg(edf_pkg::REG_HYPERPERIOD, (pad & 32'hFFFF_0000) | hyper);
      end
      for (t = 0; t < TASKS; t++) begin
        case ($urandom_range(0, 11))
          0: period = '0;
          1: period = 16'($urandom_range(1, 65535));
          default: begin
            if (hyper == 0 || hyper > 240) begin
              period = 16'($urandom_range(1, 16));
            end else begin
              period = 16'($urandom_range(1, hyper));
              while (hyper % period != 0) begin
                period = 16'($urandom_range(1, hyper));
              end
            end
          end
        endcase
        cost = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 65535))
                                           : 16'($urandom_range(0, 4));
        if ($urandom_range(0, 3) != 0) begin
          queue_cfg(edf_pkg::CFG_IDX_W'(edf_pkg::REG_TASK0_PARAMS + t), {period, cost});
        end
      end
      if ($urandom_range(0, 9) == 0) begin
        queue_cfg($urandom_range(0, 1) ? CFG_IDX_SPARE_HI : CFG_IDX_SPARE_LO, $urandom);
      end

      nticks   = $urandom_range(8, 48);
      drain_at = ($urandom_range(0, 3) == 0) ? $urandom_range(1, nticks - 1) : nticks;
      for (k = 0; k < nticks; k++) begin
        if (k == drain_at) begin
          queue_drain();
        end
        queue_tick($urandom_range(0, 39) == 0, phase_quiet);
      end
    end

    // hold reset, then release it on a falling clock edge
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // wait for every beat to be sent and every result to come back
    @(posedge clk_i);
    while (schedule_plan_q.size() != 0 || plan_active || s_axis_tvalid ||
           cfg_valid_i || expected_dispatch_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    if (fault_count == 0 && expected_dispatch_q.size() == 0) begin
      $display("PASS nonpreemptive_edf_dispatcher_unit");
    end else begin
      $display("FAIL nonpreemptive_edf_dispatcher_unit");
    end
    $finish;
  end

endmodule
